@@ hw/rtl/mfr_pkg.sv @@
// shared types, widths and helpers for the minmod face reconstruction block
`timescale 1ns / 1ps

package mfr_pkg;

  // fixed-point layout
  localparam int FRAC_BITS  = 16;
  localparam int ALPHA_FRAC = 13;
  localparam int VAL_W      = 32;
  localparam int GAP_W      = 31;
  localparam int WEIGHT_W   = 16;
  localparam int DIFF_W     = VAL_W + 1;

  // alignment of the weighted slopes
  localparam int SHL = (FRAC_BITS >= ALPHA_FRAC) ? FRAC_BITS - ALPHA_FRAC : 0;
  localparam int SHD = (FRAC_BITS >= ALPHA_FRAC) ? 0 : ALPHA_FRAC - FRAC_BITS;

  // divider widths
  localparam int NF_W  = DIFF_W + WEIGHT_W + SHL;
  localparam int NC_W  = DIFF_W + FRAC_BITS;
  localparam int QUO_W = (NF_W > NC_W) ? NF_W : NC_W;
  localparam int DIV_W = (GAP_W + SHD > GAP_W + 1) ? GAP_W + SHD : GAP_W + 1;

  // offset scaling
  localparam int HI_W      = QUO_W - 32;
  localparam int HP_W      = GAP_W + HI_W;
  localparam int LP_W      = GAP_W + 32;
  localparam int RED_SHIFT = 31 - FRAC_BITS;
  localparam int OFF_W     = 35;
  localparam logic [63:0] OFF_CAP = 64'd1 << (OFF_W - 1);
  localparam logic [63:0] HI_LIMIT = OFF_CAP >> RED_SHIFT;
  localparam int FACE_W    = OFF_W + 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(8192);

  // slope index within one direction
  localparam int SL_FWD = 0;
  localparam int SL_CEN = 1;
  localparam int SL_BWD = 2;

  // operands of the three divisions of one direction
  typedef struct packed {
    logic [2:0][QUO_W-1:0] num;
    logic [2:0][DIV_W-1:0] den;
    logic [2:0]            neg;
    logic [2:0]            dz;
  } dir_op_t;

  // one classified cell
  typedef struct packed {
    dir_op_t                 x;
    dir_op_t                 y;
    logic signed [VAL_W-1:0] center;
    logic [GAP_W-1:0]        width;
    logic [GAP_W-1:0]        height;
  } item_t;

  // data that rides beside the dividers
  typedef struct packed {
    logic [2:0]              neg_x;
    logic [2:0]              dz_x;
    logic [2:0]              neg_y;
    logic [2:0]              dz_y;
    logic signed [VAL_W-1:0] center;
    logic [GAP_W-1:0]        width;
    logic [GAP_W-1:0]        height;
  } side_t;

  // one result
  typedef struct packed {
    logic signed [VAL_W-1:0] north;
    logic signed [VAL_W-1:0] south;
    logic signed [VAL_W-1:0] east;
    logic signed [VAL_W-1:0] west;
  } face_t;

  // back part handshake status
  typedef struct packed {
    logic en;
    logic mid_pop;
    logic res_push;
  } back_stat_t;

  // clamp a wide face sum to 32 bits
  function automatic logic signed [VAL_W-1:0] sat_face(input logic signed [FACE_W-1:0] v);
    logic signed [FACE_W-1:0] hi_b;
    logic signed [FACE_W-1:0] lo_b;
    hi_b = FACE_W'(2147483647);
    lo_b = -FACE_W'(64'sd2147483648);
    if (v > hi_b) begin
      return 32'sh7fffffff;
    end else if (v < lo_b) begin
      return 32'sh80000000;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

@@ hw/rtl/mfr_queue.sv @@
// small queue with registered entries
`timescale 1ns / 1ps

module mfr_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  // flags
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/mfr_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module mfr_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rin, din, rnew;
    logic [NUM_W-1:0] nqin;
    logic [DEN_W:0]   rext;
    logic             ge;

    // stage operands: the ports for the first stage, the previous stage otherwise
    if (k == 0) begin : g_first
      assign rin  = '0;
      assign nqin = num_i;
      assign din  = den_i;
    end else begin : g_next
      assign rin  = rem_q[k-1];
      assign nqin = nq_q[k-1];
      assign din  = den_q[k-1];
    end

    // one compare and subtract step
    always_comb begin
      rext = {rin, nqin[NUM_W-1]};
      ge   = (rext >= {1'b0, din});
      rnew = ge ? DEN_W'(rext - {1'b0, din}) : DEN_W'(rext);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rnew;
        nq_q[k]  <= {nqin[NUM_W-2:0], ge};
        den_q[k] <= din;
      end
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

@@ hw/rtl/mfr_front.sv @@
// front part: differences, weighting and divisor set-up for one cell
`timescale 1ns / 1ps

module mfr_front (
  input  logic signed [mfr_pkg::VAL_W-1:0]    center_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    west_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    east_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    south_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    north_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_west_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_east_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_south_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_north_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    width_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    height_i,
  input  logic        [mfr_pkg::WEIGHT_W-1:0] weight_i,
  output mfr_pkg::item_t                      item_o
);

  import mfr_pkg::*;

  // operands of the three slopes along one direction
  function automatic dir_op_t dir_ops(
    input logic signed [VAL_W-1:0] lo_v,
    input logic signed [VAL_W-1:0] c_v,
    input logic signed [VAL_W-1:0] hi_v,
    input logic [GAP_W-1:0]        g_lo,
    input logic [GAP_W-1:0]        g_hi,
    input logic [WEIGHT_W-1:0]     alpha
  );
    dir_op_t                   r;
    logic signed [DIFF_W-1:0]  d_f, d_c, d_b;
    logic [DIFF_W-1:0]         m_f, m_c, m_b;
    logic [DIFF_W+WEIGHT_W-1:0] p_f, p_b;
    d_f = DIFF_W'(hi_v) - DIFF_W'(c_v);
    d_c = DIFF_W'(hi_v) - DIFF_W'(lo_v);
    d_b = DIFF_W'(c_v) - DIFF_W'(lo_v);
    m_f = d_f[DIFF_W-1] ? DIFF_W'(-d_f) : DIFF_W'(d_f);
    m_c = d_c[DIFF_W-1] ? DIFF_W'(-d_c) : DIFF_W'(d_c);
    m_b = d_b[DIFF_W-1] ? DIFF_W'(-d_b) : DIFF_W'(d_b);
    p_f = m_f * alpha;
    p_b = m_b * alpha;
    r.num[SL_FWD] = QUO_W'(p_f) << SHL;
    r.num[SL_CEN] = QUO_W'(m_c) << FRAC_BITS;
    r.num[SL_BWD] = QUO_W'(p_b) << SHL;
    r.den[SL_FWD] = DIV_W'(g_hi) << SHD;
    r.den[SL_CEN] = DIV_W'(g_lo) + DIV_W'(g_hi);
    r.den[SL_BWD] = DIV_W'(g_lo) << SHD;
    r.neg = {d_b[DIFF_W-1], d_c[DIFF_W-1], d_f[DIFF_W-1]};
    r.dz  = {(g_lo == '0), (r.den[SL_CEN] == '0), (g_hi == '0)};
    return r;
  endfunction

  // classify both directions
  always_comb begin
    item_o.x      = dir_ops(west_i, center_i, east_i, gap_west_i, gap_east_i, weight_i);
    item_o.y      = dir_ops(south_i, center_i, north_i, gap_south_i, gap_north_i, weight_i);
    item_o.center = center_i;
    item_o.width  = width_i;
    item_o.height = height_i;
  end

endmodule

@@ hw/rtl/mfr_back.sv @@
// back part: six dividers, minmod, offset scaling and face saturation
`timescale 1ns / 1ps

module mfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfr_pkg::item_t      head_i,
  input  logic                mid_empty_i,
  input  logic                out_full_i,
  output mfr_pkg::face_t      face_o,
  output mfr_pkg::back_stat_t stat_o
);

  import mfr_pkg::*;

  logic                 en;
  logic [2:0][QUO_W-1:0] quo_x, quo_y;

  logic  vld_q  [QUO_W];
  side_t side_q [QUO_W];

  logic                    m_vld_q, p_vld_q, s_vld_q, f_vld_q;
  logic [QUO_W-1:0]        m_mag_x_q, m_mag_y_q;
  logic                    m_neg_x_q, m_neg_y_q, p_neg_x_q, p_neg_y_q;
  logic signed [VAL_W-1:0] m_c_q, p_c_q, s_c_q;
  logic [GAP_W-1:0]        m_w_q, m_h_q;
  logic [HP_W-1:0]         p_hx_q, p_hy_q;
  logic [LP_W-1:0]         p_lx_q, p_ly_q;
  logic signed [OFF_W:0]   s_ox_q, s_oy_q;
  face_t                   f_q;

  // whole back pipeline moves unless the result queue blocks the last stage
  assign en              = !(f_vld_q && out_full_i);
  assign stat_o.en       = en;
  assign stat_o.mid_pop  = en && !mid_empty_i;
  assign stat_o.res_push = f_vld_q && !out_full_i;
  assign face_o          = f_q;

  // dividers
  for (genvar i = 0; i < 3; i++) begin : g_div
    mfr_div #(.NUM_W(QUO_W), .DEN_W(DIV_W)) u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (head_i.x.num[i]),
      .den_i (head_i.x.den[i]),
      .quo_o (quo_x[i])
    );
    mfr_div #(.NUM_W(QUO_W), .DEN_W(DIV_W)) u_div_y (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (head_i.y.num[i]),
      .den_i (head_i.y.den[i]),
      .quo_o (quo_y[i])
    );
  end

  // side data and valid bits travelling beside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QUO_W; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= !mid_empty_i;
      for (int k = 1; k < QUO_W; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].neg_x  <= head_i.x.neg;
      side_q[0].dz_x   <= head_i.x.dz;
      side_q[0].neg_y  <= head_i.y.neg;
      side_q[0].dz_y   <= head_i.y.dz;
      side_q[0].center <= head_i.center;
      side_q[0].width  <= head_i.width;
      side_q[0].height <= head_i.height;
      for (int k = 1; k < QUO_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // minmod on magnitudes: least magnitude when all three are non-zero with one sign
  function automatic logic [QUO_W:0] minmod(
    input logic [2:0][QUO_W-1:0] q,
    input logic [2:0]            neg,
    input logic [2:0]            dz
  );
    logic [QUO_W-1:0] a, b, c, m;
    logic             agree;
    a = dz[0] ? '0 : q[0];
    b = dz[1] ? '0 : q[1];
    c = dz[2] ? '0 : q[2];
    agree = (a != '0) && (b != '0) && (c != '0) && ((neg == 3'b000) || (neg == 3'b111));
    m = (a < b) ? a : b;
    m = (m < c) ? m : c;
    return agree ? {neg[0], m} : '0;
  endfunction

  // minmod stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      {m_neg_x_q, m_mag_x_q} <= minmod(quo_x, side_q[QUO_W-1].neg_x, side_q[QUO_W-1].dz_x);
      {m_neg_y_q, m_mag_y_q} <= minmod(quo_y, side_q[QUO_W-1].neg_y, side_q[QUO_W-1].dz_y);
      m_c_q <= side_q[QUO_W-1].center;
      m_w_q <= side_q[QUO_W-1].width;
      m_h_q <= side_q[QUO_W-1].height;
    end
  end

  // size times slope, split into high and low partial products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_hx_q    <= m_w_q * m_mag_x_q[QUO_W-1:32];
      p_lx_q    <= m_w_q * m_mag_x_q[31:0];
      p_hy_q    <= m_h_q * m_mag_y_q[QUO_W-1:32];
      p_ly_q    <= m_h_q * m_mag_y_q[31:0];
      p_neg_x_q <= m_neg_x_q;
      p_neg_y_q <= m_neg_y_q;
      p_c_q     <= m_c_q;
    end
  end

  // halve, rescale and cap the offset, then apply the slope sign
  function automatic logic signed [OFF_W:0] offset(
    input logic [HP_W-1:0] hi,
    input logic [LP_W-1:0] lo,
    input logic            neg
  );
    logic [63:0]      q;
    logic [OFF_W-1:0] mag;
    q = (64'(hi) << RED_SHIFT) + 64'(lo >> (FRAC_BITS + 1));
    if (64'(hi) > HI_LIMIT || q > OFF_CAP) begin
      mag = OFF_W'(OFF_CAP);
    end else begin
      mag = OFF_W'(q);
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_ox_q <= offset(p_hx_q, p_lx_q, p_neg_x_q);
      s_oy_q <= offset(p_hy_q, p_ly_q, p_neg_y_q);
      s_c_q  <= p_c_q;
    end
  end

  // face values
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q.north <= sat_face(FACE_W'(s_c_q) + FACE_W'(s_oy_q));
      f_q.south <= sat_face(FACE_W'(s_c_q) - FACE_W'(s_oy_q));
      f_q.east  <= sat_face(FACE_W'(s_c_q) + FACE_W'(s_ox_q));
      f_q.west  <= sat_face(FACE_W'(s_c_q) - FACE_W'(s_ox_q));
    end
  end

  // valid bits of the tail stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= vld_q[QUO_W-1];
      p_vld_q <= m_vld_q;
      s_vld_q <= p_vld_q;
      f_vld_q <= s_vld_q;
    end
  end

endmodule

@@ hw/rtl/minmod_face_reconstruction_2d_core.sv @@
// top level of the minmod face reconstruction block
//
// Usage: the cell request channel is queue-like. Drive the eleven cell fields
// and raise push; the request is taken on a clock edge where full is low.
// Results come out of a result queue: while empty is low the four face values
// are on the face ports, and pop on such an edge takes them.
// The weight register is written through cfg_valid_i/cfg_ready_o with the
// value on cfg_data_i; ready is always high. Write it only while idle.
// Path of a request: written into the request queue, then QUO_W divider
// stages (52 at 16 fraction bits, the first fed from the queue head), the
// 4 tail stages and the write into the result queue; the six pipelined
// dividers set the depth.
// Throughput: one cell per cycle while the back pipeline is not stalled.
// Reset clears all queues and valid bits and loads the weight with 1.0.
// When the result queue fills and pop stays low, the back pipeline freezes,
// the request queue fills behind it and full rises; nothing is dropped.
`timescale 1ns / 1ps

module minmod_face_reconstruction_2d_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [mfr_pkg::VAL_W-1:0]    center_value_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    west_value_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    east_value_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    south_value_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    north_value_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_west_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_east_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_south_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_north_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    width_x_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    height_y_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [mfr_pkg::VAL_W-1:0]    face_north_o,
  output logic signed [mfr_pkg::VAL_W-1:0]    face_south_o,
  output logic signed [mfr_pkg::VAL_W-1:0]    face_east_o,
  output logic signed [mfr_pkg::VAL_W-1:0]    face_west_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [mfr_pkg::WEIGHT_W-1:0] cfg_data_i
);

  import mfr_pkg::*;

  logic [WEIGHT_W-1:0] weight_q;
  item_t               item, head;
  logic                mid_empty, out_full;
  face_t               face, res;
  back_stat_t          stat;

  // weight register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      weight_q <= cfg_data_i;
    end
  end

  // front part
  mfr_front u_front (
    .center_i    (center_value_i),
    .west_i      (west_value_i),
    .east_i      (east_value_i),
    .south_i     (south_value_i),
    .north_i     (north_value_i),
    .gap_west_i  (gap_west_i),
    .gap_east_i  (gap_east_i),
    .gap_south_i (gap_south_i),
    .gap_north_i (gap_north_i),
    .width_i     (width_x_i),
    .height_i    (height_y_i),
    .weight_i    (weight_q),
    .item_o      (item)
  );

  // queue between front and back
  mfr_queue #(.T(item_t), .DEPTH(2)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item),
    .pop_i   (stat.mid_pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (mid_empty)
  );

  // back part
  mfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .mid_empty_i (mid_empty),
    .out_full_i  (out_full),
    .face_o      (face),
    .stat_o      (stat)
  );

  // result queue
  mfr_queue #(.T(face_t), .DEPTH(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stat.res_push),
    .data_i  (face),
    .pop_i   (pop),
    .head_o  (res),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign face_north_o = res.north;
  assign face_south_o = res.south;
  assign face_east_o  = res.east;
  assign face_west_o  = res.west;

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.mid_pop |-> !mid_empty)
    else $error("back part took from an empty queue");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.en |-> !stat.mid_pop)
    else $error("request taken while the back pipeline is stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.en |-> (out_full && !stat.res_push))
    else $error("back pipeline stalled without a full result queue");

endmodule

@@ tb/mfr_face_checker.sv @@
// checker that predicts and compares the face values of each accepted cell
`timescale 1ns / 1ps

module mfr_face_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    center_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    west_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    east_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    south_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    north_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_west_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_east_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_south_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    gap_north_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    width_i,
  input  logic        [mfr_pkg::GAP_W-1:0]    height_i,
  input  logic                                empty_i,
  input  logic                                pop_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    face_north_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    face_south_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    face_east_i,
  input  logic signed [mfr_pkg::VAL_W-1:0]    face_west_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic        [mfr_pkg::WEIGHT_W-1:0] cfg_data_i,
  output int                                  errors_o,
  output int                                  outstanding_o
);
  import mfr_pkg::*;

  logic [WEIGHT_W-1:0] weight_q;
  face_t               face_queue[$];

  // truncated quotient of diff * mul * 2^shl / den, zero divisor gives zero
  function automatic longint weighted_ratio(longint diff, longint unsigned mul, int shl,
                                            longint unsigned den);
    logic            neg;
    longint unsigned mag;
    longint unsigned quo;
    neg = diff < 0;
    mag = neg ? longint'(-diff) : longint'(diff);
    if (den == 0) return 0;
    mag = (mag * mul) << shl;
    quo = mag / den;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // generalised minmod of three slopes
  function automatic longint minmod3(longint a, longint b, longint c);
    longint m;
    if (a > 0 && b > 0 && c > 0) begin
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    end
    if (a < 0 && b < 0 && c < 0) begin
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    end
    return 0;
  endfunction

  // limited slope of one direction
  function automatic longint dir_slope(longint lo_v, longint c, longint hi_v,
                                       longint unsigned gap_lo, longint unsigned gap_hi,
                                       longint unsigned w);
    longint fwd;
    longint cen;
    longint bwd;
    fwd = weighted_ratio(hi_v - c, w, SHL, gap_hi << SHD);
    cen = weighted_ratio(hi_v - lo_v, 1, FRAC_BITS, gap_lo + gap_hi);
    bwd = weighted_ratio(c - lo_v, w, SHL, gap_lo << SHD);
    return minmod3(fwd, cen, bwd);
  endfunction

  // signed half-size times slope, magnitude capped
  function automatic longint face_offset(longint unsigned size, longint slope);
    longint unsigned smag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned q;
    longint unsigned cap;
    cap  = 64'd1 << 34;
    smag = (slope < 0) ? longint'(-slope) : longint'(slope);
    hi   = size * (smag >> 32);
    lo   = size * (smag & 64'hffff_ffff);
    if (hi > (cap >> (31 - FRAC_BITS))) q = cap;
    else q = (hi << (31 - FRAC_BITS)) + (lo >> (FRAC_BITS + 1));
    if (q > cap) q = cap;
    return (slope < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected faces of the cell currently on the request ports
  function automatic face_t predict_faces(logic [WEIGHT_W-1:0] w);
    face_t  f;
    longint c;
    longint ox;
    longint oy;
    c  = center_i;
    ox = face_offset(width_i, dir_slope(west_i, c, east_i, gap_west_i, gap_east_i, w));
    oy = face_offset(height_i, dir_slope(south_i, c, north_i, gap_south_i, gap_north_i, w));
    f.north = clamp32(c + oy);
    f.south = clamp32(c - oy);
    f.east  = clamp32(c + ox);
    f.west  = clamp32(c - ox);
    return f;
  endfunction

  // track weight, record requests, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    face_t want;
    int    bad;
    if (!rst_ni) begin
      weight_q      <= WEIGHT_RST;
      errors_o      <= 0;
      outstanding_o <= 0;
      face_queue.delete();
    end else begin
      bad = 0;
      if (cfg_valid_i && cfg_ready_i) weight_q <= cfg_data_i;
      if (push_i && !full_i) face_queue.push_back(predict_faces(weight_q));
      if (pop_i && !empty_i) begin
        if (face_queue.size() == 0) begin
          $error("face result with no request waiting");
          bad++;
        end else begin
          want = face_queue.pop_front();
          if (want.north !== face_north_i) begin
            $error("face_north expected %0d actual %0d", want.north, face_north_i);
            bad++;
          end
          if (want.south !== face_south_i) begin
            $error("face_south expected %0d actual %0d", want.south, face_south_i);
            bad++;
          end
          if (want.east !== face_east_i) begin
            $error("face_east expected %0d actual %0d", want.east, face_east_i);
            bad++;
          end
          if (want.west !== face_west_i) begin
            $error("face_west expected %0d actual %0d", want.west, face_west_i);
            bad++;
          end
        end
      end
      errors_o      <= errors_o + bad;
      outstanding_o <= face_queue.size();
    end
  end

endmodule

@@ tb/tb_minmod_face_reconstruction_2d_core.sv @@
// stimulus and verdict for the minmod face reconstruction block
`timescale 1ns / 1ps

module tb_minmod_face_reconstruction_2d_core;
  import mfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [VAL_W-1:0]    center_v = '0, west_v = '0, east_v = '0;
  logic signed [VAL_W-1:0]    south_v = '0, north_v = '0;
  logic        [GAP_W-1:0]    gw = GAP_W'(1), ge = GAP_W'(1), gs = GAP_W'(1);
  logic        [GAP_W-1:0]    gn = GAP_W'(1), wx = GAP_W'(1), hy = GAP_W'(1);
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [VAL_W-1:0]    fn, fs, fe, fw;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic        [WEIGHT_W-1:0] cfg_data = '0;
  int                         errors;
  int                         outstanding;
  int                         cycles = 0;
  int                         burst_left = 0;

  minmod_face_reconstruction_2d_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .center_value_i(center_v), .west_value_i(west_v), .east_value_i(east_v),
    .south_value_i(south_v), .north_value_i(north_v),
    .gap_west_i(gw), .gap_east_i(ge), .gap_south_i(gs), .gap_north_i(gn),
    .width_x_i(wx), .height_y_i(hy), .empty(empty), .pop(pop),
    .face_north_o(fn), .face_south_o(fs), .face_east_o(fe), .face_west_o(fw),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  mfr_face_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .full_i(full),
    .center_i(center_v), .west_i(west_v), .east_i(east_v),
    .south_i(south_v), .north_i(north_v),
    .gap_west_i(gw), .gap_east_i(ge), .gap_south_i(gs), .gap_north_i(gn),
    .width_i(wx), .height_i(hy), .empty_i(empty), .pop_i(pop),
    .face_north_i(fn), .face_south_i(fs), .face_east_i(fe), .face_west_i(fw),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("minmod_face_reconstruction_2d_core: mismatch");
      $finish;
    end
  end

  // receiver: changing stall pattern, one long hold-off
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (cycles == 1500) hold = 600;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          2: pop <= ($urandom_range(0, 9) == 0);
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // offer one cell request, return once it is taken
  task automatic send_cell(input logic [31:0] c, w, e, s, n,
                           input logic [30:0] g_w, g_e, g_s, g_n, sx, sy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    center_v <= c; west_v <= w; east_v <= e; south_v <= s; north_v <= n;
    gw <= g_w; ge <= g_e; gs <= g_s; gn <= g_n; wx <= sx; hy <= sy;
    do @(posedge clk_i); while (full);
  endtask

  // drain, then write the weight register
  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] rand_gap();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2, 3: return 31'($urandom());
      default: return 31'($urandom_range(1, 32'h0002_0000));
    endcase
  endfunction

  function automatic logic [31:0] clamp_val(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // random cell: mostly monotone neighbours so the limiter has a slope
  task automatic send_random_cell();
    longint c;
    longint sx;
    longint sy;
    logic [31:0] v[5];
    c = longint'($signed($urandom()));
    if ($urandom_range(0, 3) == 0) begin
      foreach (v[i]) v[i] = $urandom();
    end else begin
      sx = ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(0, 32'h0100_0000));
      sy = ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(0, 32'h0100_0000));
      if ($urandom_range(0, 3) == 0) c = longint'($signed($urandom_range(0, 32'h00ff_ffff)));
      v[0] = clamp_val(c);
      v[1] = clamp_val(c - sx * $urandom_range(0, 4));
      v[2] = clamp_val(c + sx * $urandom_range(0, 4));
      v[3] = clamp_val(c - sy * $urandom_range(0, 4));
      v[4] = clamp_val(c + sy * $urandom_range(0, 4));
    end
    send_cell(v[0], v[1], v[2], v[3], v[4],
              rand_gap(), rand_gap(), rand_gap(), rand_gap(), rand_gap(), rand_gap());
  endtask

  // main stimulus and verdict
  initial begin
    logic [30:0] one;
    logic [30:0] gmax;
    logic [30:0] tiny;
    logic [30:0] nil;
    one  = 31'h0001_0000;
    gmax = 31'h7fffffff;
    tiny = 31'd1;
    nil  = 31'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero divisors, zero sizes, saturation
    set_weight(16'd8192);
    send_cell(0, 0, 0, 0, 0, one, one, one, one, one, one);
    send_cell(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              gmax, gmax, gmax, gmax, gmax, gmax);
    send_cell(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              gmax, gmax, gmax, gmax, gmax, gmax);
    send_cell(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              tiny, tiny, tiny, tiny, gmax, gmax);
    send_cell(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              tiny, tiny, tiny, tiny, gmax, gmax);
    send_cell(32'h7fff0000, 32'h0, 32'h7fffffff, 32'h0, 32'h7fffffff,
              tiny, tiny, tiny, tiny, gmax, gmax);
    send_cell(32'h80010000, 32'h0, 32'h80000000, 32'h0, 32'h80000000,
              tiny, tiny, tiny, tiny, gmax, gmax);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, one, one, one, one, one, one);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, nil, one, one, nil, one, one);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, nil, nil, nil, nil, one, one);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, one, one, one, one, nil, nil);
    send_cell(32'h00010000, 32'h00020000, 32'h00030000, 32'h00020000, 0,
              one, one, one, one, one, one);
    send_cell(32'h00050000, 32'h00090000, 32'h00010000, 32'h00010000, 32'h00090000,
              31'h8000, 31'h30000, one, one, 31'h28000, 31'h18000);
    send_cell(32'hffff0000, 32'hfffe0000, 32'hffff0000, 32'h00000000, 32'hfffe0000,
              one, one, one, one, one, one);
    set_weight(16'd0);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, one, one, one, one, one, one);
    send_cell(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              tiny, tiny, tiny, tiny, gmax, gmax);
    set_weight(16'hffff);
    send_cell(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              tiny, tiny, tiny, tiny, gmax, gmax);
    send_cell(32'h00010000, 0, 32'h00020000, 0, 32'h00020000, one, one, one, one, one, one);
    send_cell(32'h00010000, 32'h0000fff0, 32'h00010010, 32'hffffffff, 32'h00020000,
              gmax, tiny, tiny, gmax, gmax, tiny);

    // random phases with several weights
    set_weight(16'd8192);
    repeat (800) send_random_cell();
    set_weight(16'd16384);
    repeat (300) send_random_cell();
    set_weight(16'd1);
    repeat (250) send_random_cell();
    set_weight(16'hffff);
    repeat (250) send_random_cell();
    set_weight(16'd0);
    repeat (100) send_random_cell();
    set_weight(WEIGHT_W'($urandom_range(0, 16'hffff)));
    repeat (230) send_random_cell();

    // drain and verdict
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("minmod_face_reconstruction_2d_core: match");
    end else begin
      $display("minmod_face_reconstruction_2d_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_queue.sv
hw/rtl/mfr_div.sv
hw/rtl/mfr_front.sv
hw/rtl/mfr_back.sv
hw/rtl/minmod_face_reconstruction_2d_core.sv
tb/mfr_face_checker.sv
tb/tb_minmod_face_reconstruction_2d_core.sv
